// ===== rtl/core/directory_existence_hash_cache_assert.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the directory existence hash cache
// Shared forms of the concurrent checks used by the port checker.
// -----------------------------------------------------------------------------
`ifndef DIRECTORY_EXISTENCE_HASH_CACHE_ASSERT_SVH
`define DIRECTORY_EXISTENCE_HASH_CACHE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define DEHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DEHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dehc_pkg.sv =====
// -----------------------------------------------------------------------------
// Directory existence hash cache package
// Types, sizes and codes shared by the cache modules.
// -----------------------------------------------------------------------------
package dehc_pkg;

  localparam int TABLE_ENTRIES = 512;
  localparam int KEY_BYTES     = 128;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int KIDX_W        = $clog2(KEY_BYTES);
  localparam int POS_W         = 16;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [7:0]  SLASH     = 8'h2F;

  localparam logic OP_PATH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_EXISTS  = 2'd1;
  localparam logic [1:0] MARK_MISSING = 2'd2;

  localparam logic [1:0] OUT_HIT     = 2'd0;
  localparam logic [1:0] OUT_STORED  = 2'd1;
  localparam logic [1:0] OUT_FULL    = 2'd2;
  localparam logic [1:0] OUT_NOCACHE = 2'd3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] path_byte;
    logic       last_byte;
    logic       card_says_dir;
  } req_t;

  typedef struct packed {
    logic        might_exist;
    logic [1:0]  outcome;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] overflow_total;
  } rsp_t;

  typedef struct packed {
    logic              go;
    logic              cacheable;
    logic [KIDX_W-1:0] dlen;
    logic [31:0]       hash;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [KIDX_W-1:0] addr;
    logic [7:0]        data;
  } pbw_t;

endpackage

// ===== rtl/core/dehc_front.sv =====
// -----------------------------------------------------------------------------
// Path front end
// Hashes path bytes with FNV-1a and tracks the prefix before the last slash.
// -----------------------------------------------------------------------------
module dehc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        path_byte,
  input  logic              last_byte,
  output dehc_pkg::job_t    job,
  output dehc_pkg::pbw_t    pbw
);

  logic [31:0]                 hash;
  logic [31:0]                 prefix;
  logic [dehc_pkg::POS_W-1:0]  pos;
  logic [dehc_pkg::POS_W-1:0]  lsp;
  logic                        seen;

  logic                        slash;
  logic [31:0]                 prefix_next;
  logic [dehc_pkg::POS_W-1:0]  lsp_next;
  logic                        seen_next;
  logic [31:0]                 hash_next;

  always_comb begin
    slash       = (path_byte == dehc_pkg::SLASH);
    prefix_next = slash ? hash : prefix;
    lsp_next    = slash ? pos : lsp;
    seen_next   = slash | seen;
    hash_next   = (hash ^ {24'd0, path_byte}) * dehc_pkg::FNV_PRIME;
    job.go        = take & last_byte;
    job.cacheable = seen_next && (lsp_next != '0) &&
                    (lsp_next < dehc_pkg::POS_W'(dehc_pkg::KEY_BYTES));
    job.dlen      = lsp_next[dehc_pkg::KIDX_W-1:0];
    job.hash      = prefix_next;
    pbw.we   = take && (pos < dehc_pkg::POS_W'(dehc_pkg::KEY_BYTES));
    pbw.addr = pos[dehc_pkg::KIDX_W-1:0];
    pbw.data = path_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash   <= dehc_pkg::FNV_BASIS;
      prefix <= '0;
      pos    <= '0;
      lsp    <= '0;
      seen   <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        hash   <= dehc_pkg::FNV_BASIS;
        prefix <= '0;
        pos    <= '0;
        lsp    <= '0;
        seen   <= 1'b0;
      end else begin
        hash   <= hash_next;
        prefix <= prefix_next;
        lsp    <= lsp_next;
        seen   <= seen_next;
        if (pos != '1) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/dehc_table.sv =====
// -----------------------------------------------------------------------------
// Probe table
// Marks, key lengths, key bytes and the path buffer with the probe sequencer.
// -----------------------------------------------------------------------------
module dehc_table (
  input  logic            clk,
  input  logic            rst,
  input  dehc_pkg::job_t  job,
  input  dehc_pkg::pbw_t  pbw,
  input  logic            card_says_dir,
  input  logic            clear,
  output logic            idle,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output dehc_pkg::rsp_t  rsp_data
);

  localparam int SW = dehc_pkg::SLOT_W;
  localparam int KW = dehc_pkg::KIDX_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_PREAD = 4'd2;
  localparam logic [3:0] S_PCHK  = 4'd3;
  localparam logic [3:0] S_CRD   = 4'd4;
  localparam logic [3:0] S_CEQ   = 4'd5;
  localparam logic [3:0] S_YRD   = 4'd6;
  localparam logic [3:0] S_YWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [1:0]    mark_mem [dehc_pkg::TABLE_ENTRIES];
  logic [KW-1:0] len_mem  [dehc_pkg::TABLE_ENTRIES];
  logic [7:0]    key_mem  [dehc_pkg::TABLE_ENTRIES * dehc_pkg::KEY_BYTES];
  logic [7:0]    pb_mem   [dehc_pkg::KEY_BYTES];

  logic [1:0]    mark_rd;
  logic [KW-1:0] len_rd;
  logic [7:0]    key_rd;
  logic [7:0]    pb_rd;

  logic [3:0]    state;
  logic [SW-1:0] clr_idx;
  logic [SW-1:0] probe;
  logic [31:0]   hash;
  logic [KW-1:0] dlen;
  logic [KW-1:0] idx;
  logic          card;
  logic [SW:0]   entry_total;
  logic [31:0]   hit_cnt;
  logic [31:0]   miss_cnt;
  logic [31:0]   ovf_cnt;
  logic          res_exists;
  logic [1:0]    res_outcome;

  logic [SW-1:0] slot;
  logic          mark_we;
  logic [SW-1:0] mark_wa;
  logic [1:0]    mark_wd;
  logic          len_we;
  logic          key_we;

  always_comb begin
    slot    = hash[SW-1:0] + probe;
    mark_we = 1'b0;
    mark_wa = slot;
    mark_wd = card ? dehc_pkg::MARK_EXISTS : dehc_pkg::MARK_MISSING;
    len_we  = 1'b0;
    key_we  = (state == S_YWR);
    if (state == S_CLEAR) begin
      mark_we = 1'b1;
      mark_wa = clr_idx;
      mark_wd = dehc_pkg::MARK_EMPTY;
    end else if (state == S_PCHK && mark_rd == dehc_pkg::MARK_EMPTY &&
                 entry_total < (SW+1)'(dehc_pkg::TABLE_ENTRIES - 1)) begin
      mark_we = 1'b1;
      len_we  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    mark_rd <= mark_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[slot] <= dlen;
    end
    len_rd <= len_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[{slot, idx}] <= pb_rd;
    end
    key_rd <= key_mem[{slot, idx}];
  end

  always_ff @(posedge clk) begin
    if (pbw.we) begin
      pb_mem[pbw.addr] <= pbw.data;
    end
    pb_rd <= pb_mem[idx];
  end

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      probe       <= '0;
      idx         <= '0;
      entry_total <= '0;
      hit_cnt     <= '0;
      miss_cnt    <= '0;
      ovf_cnt     <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (clear) begin
            clr_idx <= '0;
            state   <= S_CLEAR;
          end else if (job.go) begin
            hash  <= job.hash;
            dlen  <= job.dlen;
            card  <= card_says_dir;
            probe <= '0;
            idx   <= '0;
            if (job.cacheable) begin
              state <= S_PREAD;
            end else begin
              res_exists  <= 1'b1;
              res_outcome <= dehc_pkg::OUT_NOCACHE;
              state       <= S_DONE;
            end
          end
        end
        S_CLEAR: begin
          entry_total <= '0;
          clr_idx     <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            state <= S_IDLE;
          end
        end
        S_PREAD: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          idx <= '0;
          if (mark_rd == dehc_pkg::MARK_EMPTY) begin
            miss_cnt   <= miss_cnt + 1'b1;
            res_exists <= card;
            if (mark_we) begin
              entry_total <= entry_total + 1'b1;
              res_outcome <= dehc_pkg::OUT_STORED;
              state       <= S_YRD;
            end else begin
              ovf_cnt     <= ovf_cnt + 1'b1;
              res_outcome <= dehc_pkg::OUT_FULL;
              state       <= S_DONE;
            end
          end else if (len_rd == dlen) begin
            state <= S_CRD;
          end else if (probe == '1) begin
            res_exists  <= 1'b1;
            res_outcome <= dehc_pkg::OUT_NOCACHE;
            state       <= S_DONE;
          end else begin
            probe <= probe + 1'b1;
            state <= S_PREAD;
          end
        end
        S_CRD: begin
          state <= S_CEQ;
        end
        S_CEQ: begin
          if (pb_rd != key_rd) begin
            if (probe == '1) begin
              res_exists  <= 1'b1;
              res_outcome <= dehc_pkg::OUT_NOCACHE;
              state       <= S_DONE;
            end else begin
              probe <= probe + 1'b1;
              state <= S_PREAD;
            end
          end else if (idx == dlen - 1'b1) begin
            hit_cnt     <= hit_cnt + 1'b1;
            res_exists  <= (mark_rd == dehc_pkg::MARK_EXISTS);
            res_outcome <= dehc_pkg::OUT_HIT;
            state       <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_CRD;
          end
        end
        S_YRD: begin
          state <= S_YWR;
        end
        S_YWR: begin
          if (idx == dlen - 1'b1) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_YRD;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid               <= 1'b1;
            rsp_data.might_exist    <= res_exists;
            rsp_data.outcome        <= res_outcome;
            rsp_data.hit_total      <= hit_cnt;
            rsp_data.miss_total     <= miss_cnt;
            rsp_data.overflow_total <= ovf_cnt;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/directory_existence_hash_cache.sv =====
// Flow: a path byte that is not last is hashed and buffered. A final byte of a
// path that cannot be cached goes straight to the done state; else each probed
// slot is read and checked, key bytes are compared one by one, and at an empty
// slot with room the key is stored. One path byte is taken per cycle while the
// table is idle; a held result keeps the next lookup in its done state until the
// output register frees. Reset and clear wipe all marks and take no item then.
// -----------------------------------------------------------------------------
// Directory existence hash cache
// FNV-1a keyed, linearly probed cache of directory existence answers.
// -----------------------------------------------------------------------------
module directory_existence_hash_cache (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  dehc_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output dehc_pkg::rsp_t  rsp_data
);

  dehc_pkg::job_t job;
  dehc_pkg::pbw_t pbw;
  logic           xfer;
  logic           take;
  logic           clear;

  assign xfer  = req_valid && req_ready;
  assign take  = xfer && (req_data.opcode == dehc_pkg::OP_PATH);
  assign clear = xfer && (req_data.opcode == dehc_pkg::OP_CLEAR);

  dehc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .path_byte (req_data.path_byte),
    .last_byte (req_data.last_byte),
    .job       (job),
    .pbw       (pbw)
  );

  dehc_table u_table (
    .clk           (clk),
    .rst           (rst),
    .job           (job),
    .pbw           (pbw),
    .card_says_dir (req_data.card_says_dir),
    .clear         (clear),
    .idle          (req_ready),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp_data      (rsp_data)
  );

endmodule

// ===== rtl/core/dehc_checker.sv =====
// -----------------------------------------------------------------------------
// Port checker
// Concurrent checks on the ports of the directory existence hash cache.
// -----------------------------------------------------------------------------
`include "directory_existence_hash_cache_assert.svh"

module dehc_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input dehc_pkg::req_t  req_data,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input dehc_pkg::rsp_t  rsp_data
);

  `DEHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
  `DEHC_ASSERT_NEXT(a_clear_busy, req_valid && req_ready && req_data.opcode == dehc_pkg::OP_CLEAR, !req_ready, "clear pass skipped")
  `DEHC_ASSERT_NOW(a_nocache, rsp_valid && rsp_data.outcome == dehc_pkg::OUT_NOCACHE, rsp_data.might_exist, "uncacheable path not answered as existing")
  `DEHC_ASSERT_NEXT(a_last_busy, req_valid && req_ready && req_data.opcode == dehc_pkg::OP_PATH && req_data.last_byte, !req_ready, "final byte transfer did not start a lookup")

endmodule

bind directory_existence_hash_cache dehc_checker u_dehc_checker (.*);
